### src/three_axis_moving_average_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three-axis moving average unit
// Expect clk and arst_n in the scope that uses them.
// ---------------------------------------------------------------------------
`ifndef THREE_AXIS_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define THREE_AXIS_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define TAMA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define TAMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tama_pkg.sv
// ---------------------------------------------------------------------------
// tama_pkg
// Shared widths, sample types and the store port structs.
// ---------------------------------------------------------------------------
package tama_pkg;

	localparam int AXES        = 3;
	localparam int SAMPLE_BITS = 16;
	// window length; a power of two, so the mean is a shift
	localparam int DEPTH       = 128;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int SUM_W       = SAMPLE_BITS + ADDR_W;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [SUM_W-1:0]  TRUNC_BIAS = SUM_W'(DEPTH - 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [AXES-1:0]            triple_t;
	typedef logic signed [SUM_W-1:0]       sum_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		triple_t           data;
	} wr_t;

	typedef struct packed {
		logic              old_ok;
		logic [ADDR_W-1:0] addr;
		triple_t           data;
	} rd_t;

endpackage

### src/tama_store.sv
// ---------------------------------------------------------------------------
// tama_store
// Circular sample memory (one word holds X, Y, Z) with its write pointer.
// Reads the oldest word on each accepted item; a word not yet written
// since reset is flagged so that it counts as zero.
// ---------------------------------------------------------------------------
module tama_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  tama_pkg::wr_t wr,
	output tama_pkg::rd_t rd
);
	import tama_pkg::*;

	triple_t           mem_q [DEPTH];
	logic [ADDR_W-1:0] ptr_q;
	logic              wrapped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (rd_en) begin
			if (ptr_q == LAST_ADDR) begin
				ptr_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd.data   <= mem_q[ptr_q];
			rd.addr   <= ptr_q;
			rd.old_ok <= wrapped_q;
		end
	end

endmodule

### src/tama_accum.sv
// ---------------------------------------------------------------------------
// tama_accum
// Running window sums per axis and the output sum register. The mean is
// the registered sum divided by the window length, truncated toward zero.
// ---------------------------------------------------------------------------
module tama_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  tama_pkg::triple_t fresh,
	input  tama_pkg::rd_t     old,
	output tama_pkg::triple_t avg
);
	import tama_pkg::*;

	sum_t sums_q [AXES];
	sum_t sum_s2 [AXES];
	sum_t next_sum [AXES];
	sum_t old_v [AXES];
	sum_t biased [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			// an entry not yet written since reset counts as zero
			old_v[a]    = old.old_ok ? sum_t'($signed(old.data[a])) : '0;
			next_sum[a] = sums_q[a] + sum_t'($signed(fresh[a])) - old_v[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				sums_q[a] <= '0;
			end
		end else if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				sums_q[a] <= next_sum[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				sum_s2[a] <= next_sum[a];
			end
		end
	end

	// bias negative sums so the arithmetic shift truncates toward zero
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			biased[a] = sum_s2[a] + (sum_s2[a][SUM_W-1] ? TRUNC_BIAS : '0);
			avg[a]    = biased[a][SUM_W-1:ADDR_W];
		end
	end

endmodule

### src/three_axis_moving_average_unit.sv
// ---------------------------------------------------------------------------
// three_axis_moving_average_unit
// Moving average over the last 128 samples of each of three axes.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid, in_stall   | sample_x, sample_y, sample_z
//  out     | source    | out_valid, out_stall | average_x, average_y, average_z
//
//  One word per cycle sustained while the output does not stall; the
//  average word is offered once its sample word has passed both stages.
//  Stage one reads the oldest sample from the memory; stage two adds the
//  new sample, removes the old one, writes back and registers the sum.
//  Reset clears the pointer and sums; unwritten memory reads as zero.
//  A stalled output holds the result and backs up into the input.
// ---------------------------------------------------------------------------
`include "three_axis_moving_average_unit_defines.svh"

module three_axis_moving_average_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  tama_pkg::sample_t       sample_x,
	input  tama_pkg::sample_t       sample_y,
	input  tama_pkg::sample_t       sample_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output tama_pkg::sample_t       average_x,
	output tama_pkg::sample_t       average_y,
	output tama_pkg::sample_t       average_z
);
	import tama_pkg::*;

	logic    s1_valid_q;
	logic    out_valid_q;
	logic    s1_adv;
	logic    in_acc;
	triple_t samples_s1;
	triple_t avg;
	wr_t     wr;
	rd_t     rd;

	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			samples_s1[0] <= sample_x;
			samples_s1[1] <= sample_y;
			samples_s1[2] <= sample_z;
		end
	end

	// write the new word back over the one just read
	assign wr.en   = s1_adv;
	assign wr.addr = rd.addr;
	assign wr.data = samples_s1;

	tama_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc),
		.wr     (wr),
		.rd     (rd)
	);

	tama_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (s1_adv),
		.fresh  (samples_s1),
		.old    (rd),
		.avg    (avg)
	);

	assign out_valid = out_valid_q;
	assign average_x = avg[0];
	assign average_y = avg[1];
	assign average_z = avg[2];

	`TAMA_ASSERT_NOW(a_s1_no_overrun, in_acc && s1_valid_q, s1_adv, "stage one overwritten")
	`TAMA_ASSERT_NOW(a_backpressure, s1_valid_q && out_valid_q && out_stall, in_stall, "no stall")
	`TAMA_ASSERT_NXT(a_result_follows, s1_adv, out_valid_q, "advanced word lost")

endmodule
